### rtl/core/ffe_pkg.sv
// shared types, constants and codes for the frame feature extractor
package ffe_pkg;

   localparam int SAMPLE_W   = 24;
   localparam int VALUE_W    = 48;
   localparam int KIND_W     = 3;
   localparam int MODE_W     = 2;
   localparam int THR_W      = 24;
   localparam int DIST_W     = 16;
   localparam int COUNT_W    = 17;
   localparam int POS_W      = 16;
   localparam int ACC_W      = 64;
   localparam int PROD_W     = 2 * SAMPLE_W;
   localparam int REM_W      = COUNT_W;
   localparam int DIV_CNT_W  = 6;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;

   localparam logic [COUNT_W-1:0] MAX_FRAME = COUNT_W'(65536);

   localparam logic [MODE_W-1:0] MODE_MEAN   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_ENERGY = 2'd1;
   localparam logic [MODE_W-1:0] MODE_PEAK   = 2'd2;
   localparam logic [MODE_W-1:0] MODE_PASS   = 2'd3;

   localparam logic [KIND_W-1:0] KIND_SAMPLE = 3'd0;
   localparam logic [KIND_W-1:0] KIND_MEAN   = 3'd1;
   localparam logic [KIND_W-1:0] KIND_ENERGY = 3'd2;
   localparam logic [KIND_W-1:0] KIND_PEAK   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_END    = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_MODE      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_DIST  = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_ACC,
      ST_EMIT,
      ST_DIV,
      ST_FINAL
   } state_type;

   typedef struct packed {
      logic load_req;
      logic exec;
      logic acc;
      logic div_start;
      logic div_step;
      logic emit_primary;
      logic emit_final;
      logic clear_frame;
   } cmd_type;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic              last;
      logic              peak_hit;
      logic              out_free;
      logic              div_last;
   } status_type;

endpackage

### rtl/core/ffe_ctrl.sv
// controller state machine: sequences request intake, update, square accumulate, output, divide and final result
module ffe_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  ffe_pkg::status_type status,
   output ffe_pkg::cmd_type    cmd
);

   ffe_pkg::state_type state_ff;
   ffe_pkg::state_type state_in;
   logic               primary_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ffe_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign primary_ok = (status.mode == ffe_pkg::MODE_PASS) ||
                       ((status.mode == ffe_pkg::MODE_PEAK) && status.peak_hit);

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ffe_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               state_in     = ffe_pkg::ST_EXEC;
            end
         end
         ffe_pkg::ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = ffe_pkg::ST_ACC;
         end
         ffe_pkg::ST_ACC: begin
            cmd.acc  = 1'b1;
            state_in = ffe_pkg::ST_EMIT;
         end
         ffe_pkg::ST_EMIT: begin
            if (!primary_ok || status.out_free) begin
               cmd.emit_primary = primary_ok;
               if (!status.last) begin
                  state_in = ffe_pkg::ST_IDLE;
               end else begin
                  case (status.mode)
                     ffe_pkg::MODE_MEAN, ffe_pkg::MODE_ENERGY: begin
                        cmd.div_start = 1'b1;
                        state_in      = ffe_pkg::ST_DIV;
                     end
                     ffe_pkg::MODE_PEAK: begin
                        state_in = ffe_pkg::ST_FINAL;
                     end
                     default: begin
                        cmd.clear_frame = 1'b1;
                        state_in        = ffe_pkg::ST_IDLE;
                     end
                  endcase
               end
            end
         end
         ffe_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ffe_pkg::ST_FINAL;
            end
         end
         ffe_pkg::ST_FINAL: begin
            if (status.out_free) begin
               cmd.emit_final  = 1'b1;
               cmd.clear_frame = 1'b1;
               state_in        = ffe_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ffe_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

### rtl/core/ffe_dp.sv
// datapath: config registers, frame state, squarer, serial divider, output register
module ffe_dp (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_we,
   input  logic [ffe_pkg::CSR_IDX_W-1:0]           csr_index,
   input  logic [ffe_pkg::CSR_DATA_W-1:0]          csr_wdata,
   input  logic signed [ffe_pkg::SAMPLE_W-1:0]     req_sample,
   input  logic                                    req_last,
   input  ffe_pkg::cmd_type                        cmd,
   output ffe_pkg::status_type                     status,
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   output logic [ffe_pkg::VALUE_W-1:0]             rsp_value,
   output logic [ffe_pkg::KIND_W-1:0]              rsp_kind,
   output logic                                    rsp_done
);

   localparam int EXT_W = ffe_pkg::VALUE_W - ffe_pkg::SAMPLE_W;

   // configuration
   logic [ffe_pkg::MODE_W-1:0]         mode_ff;
   logic signed [ffe_pkg::THR_W-1:0]   thr_ff;
   logic [ffe_pkg::DIST_W-1:0]         min_dist_ff;

   // current request
   logic signed [ffe_pkg::SAMPLE_W-1:0] s_ff;
   logic                                last_ff;

   // frame state
   logic signed [ffe_pkg::SAMPLE_W-1:0] prev_ff;
   logic signed [ffe_pkg::SAMPLE_W-1:0] prev2_ff;
   logic [ffe_pkg::COUNT_W-1:0]         count_ff;
   logic [ffe_pkg::ACC_W-1:0]           acc_ff;
   logic [ffe_pkg::POS_W-1:0]           last_peak_ff;
   logic                                peak_seen_ff;

   logic signed [ffe_pkg::PROD_W-1:0]   prod_ff;
   logic                                taken_ff;
   logic                                peak_hit_ff;
   logic [ffe_pkg::POS_W-1:0]           peak_pos_ff;

   // divider
   logic [ffe_pkg::ACC_W-1:0]           quo_ff;
   logic [ffe_pkg::REM_W-1:0]           rem_ff;
   logic [ffe_pkg::COUNT_W-1:0]         divisor_ff;
   logic [ffe_pkg::DIV_CNT_W-1:0]       div_cnt_ff;
   logic                                neg_ff;

   // output register
   logic                                rsp_valid_ff;
   logic [ffe_pkg::VALUE_W-1:0]         rsp_value_ff;
   logic [ffe_pkg::KIND_W-1:0]          rsp_kind_ff;
   logic                                rsp_done_ff;

   logic                                taken;
   logic [ffe_pkg::POS_W-1:0]           pos;
   logic [ffe_pkg::POS_W-1:0]           gap;
   logic                                is_peak;
   logic [ffe_pkg::REM_W:0]             trial;
   logic                                trial_ge;
   logic [ffe_pkg::ACC_W-1:0]           acc_neg;
   logic                                acc_is_neg;
   logic [ffe_pkg::ACC_W-1:0]           quo_neg;
   logic                                out_free;

   assign taken      = count_ff < ffe_pkg::MAX_FRAME;
   assign pos        = ffe_pkg::POS_W'(count_ff - ffe_pkg::COUNT_W'(1));
   assign gap        = pos - last_peak_ff;
   assign is_peak    = (count_ff >= ffe_pkg::COUNT_W'(2)) &&
                       (prev_ff > prev2_ff) && (prev_ff > s_ff) && (prev_ff > thr_ff) &&
                       (!peak_seen_ff || (gap >= min_dist_ff));
   assign trial      = {rem_ff, quo_ff[ffe_pkg::ACC_W-1]};
   assign trial_ge   = trial >= {1'b0, divisor_ff};
   assign acc_neg    = ~acc_ff + ffe_pkg::ACC_W'(1);
   assign acc_is_neg = (mode_ff == ffe_pkg::MODE_MEAN) && acc_ff[ffe_pkg::ACC_W-1];
   assign quo_neg    = ~quo_ff + ffe_pkg::ACC_W'(1);
   assign out_free   = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= ffe_pkg::MODE_PASS;
         thr_ff      <= '0;
         min_dist_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            ffe_pkg::CSR_MODE:      mode_ff     <= csr_wdata[ffe_pkg::MODE_W-1:0];
            ffe_pkg::CSR_THRESHOLD: thr_ff      <= csr_wdata[ffe_pkg::THR_W-1:0];
            ffe_pkg::CSR_MIN_DIST:  min_dist_ff <= csr_wdata[ffe_pkg::DIST_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         s_ff    <= req_sample;
         last_ff <= req_last;
      end
      if (cmd.exec) begin
         prod_ff     <= s_ff * s_ff;
         taken_ff    <= taken;
         peak_hit_ff <= taken && (mode_ff == ffe_pkg::MODE_PEAK) && is_peak;
         peak_pos_ff <= pos;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear_frame) begin
         prev_ff      <= '0;
         prev2_ff     <= '0;
         count_ff     <= '0;
         acc_ff       <= '0;
         last_peak_ff <= '0;
         peak_seen_ff <= 1'b0;
      end else if (cmd.exec) begin
         if (taken) begin
            if (mode_ff == ffe_pkg::MODE_MEAN) begin
               acc_ff <= acc_ff + ffe_pkg::ACC_W'(s_ff);
            end
            if ((mode_ff == ffe_pkg::MODE_PEAK) && is_peak) begin
               last_peak_ff <= pos;
               peak_seen_ff <= 1'b1;
            end
            prev2_ff <= prev_ff;
            prev_ff  <= s_ff;
            count_ff <= count_ff + ffe_pkg::COUNT_W'(1);
         end
      end else if (cmd.acc) begin
         // square arrives in the cycle after the sample
         if (taken_ff && (mode_ff == ffe_pkg::MODE_ENERGY)) begin
            acc_ff <= acc_ff + ffe_pkg::ACC_W'(unsigned'(prod_ff));
         end
      end
   end

   // restoring divide, one quotient bit per cycle
   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         quo_ff     <= acc_is_neg ? acc_neg : acc_ff;
         neg_ff     <= acc_is_neg;
         rem_ff     <= '0;
         divisor_ff <= (count_ff == '0) ? ffe_pkg::COUNT_W'(1) : count_ff;
         div_cnt_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff     <= trial_ge ? ffe_pkg::REM_W'(trial - {1'b0, divisor_ff})
                                : trial[ffe_pkg::REM_W-1:0];
         quo_ff     <= {quo_ff[ffe_pkg::ACC_W-2:0], trial_ge};
         div_cnt_ff <= div_cnt_ff + ffe_pkg::DIV_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit_primary || cmd.emit_final) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_primary) begin
         if (mode_ff == ffe_pkg::MODE_PASS) begin
            rsp_value_ff <= {{EXT_W{s_ff[ffe_pkg::SAMPLE_W-1]}}, s_ff};
            rsp_kind_ff  <= ffe_pkg::KIND_SAMPLE;
            rsp_done_ff  <= last_ff;
         end else begin
            rsp_value_ff <= ffe_pkg::VALUE_W'(peak_pos_ff);
            rsp_kind_ff  <= ffe_pkg::KIND_PEAK;
            rsp_done_ff  <= 1'b0;
         end
      end else if (cmd.emit_final) begin
         rsp_done_ff <= 1'b1;
         case (mode_ff)
            ffe_pkg::MODE_MEAN: begin
               rsp_value_ff <= neg_ff ? quo_neg[ffe_pkg::VALUE_W-1:0]
                                      : quo_ff[ffe_pkg::VALUE_W-1:0];
               rsp_kind_ff  <= ffe_pkg::KIND_MEAN;
            end
            ffe_pkg::MODE_ENERGY: begin
               rsp_value_ff <= quo_ff[ffe_pkg::VALUE_W-1:0];
               rsp_kind_ff  <= ffe_pkg::KIND_ENERGY;
            end
            default: begin
               rsp_value_ff <= '0;
               rsp_kind_ff  <= ffe_pkg::KIND_END;
            end
         endcase
      end
   end

   assign status.mode     = mode_ff;
   assign status.last     = last_ff;
   assign status.peak_hit = peak_hit_ff;
   assign status.out_free = out_free;
   assign status.div_last = &div_cnt_ff;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_kind   = rsp_kind_ff;
   assign rsp_done   = rsp_done_ff;

endmodule

### rtl/core/frame_feature_extractor_core.sv
// frame feature extractor: mean, energy, peak positions or passthrough per frame
// a request is accepted only in idle, then steps through update, square accumulate and
// output; the result is registered at the output step. mean and energy frame ends add the
// bit-serial 64-bit divide before the end result, peak frame ends add a final state for
// the end marker. a new request is taken only once the last one is through, and results
// wait on rsp_tready; the divider and single-issue controller set this.
// reset: synchronous; mode passthrough, threshold 0, min distance 0, frame state clear
module frame_feature_extractor_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [ffe_pkg::SAMPLE_W-1:0]       req_tdata,   // [23:0] sample
   input  logic                               req_tlast,   // frame_last
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [ffe_pkg::VALUE_W-1:0]        rsp_tdata,   // [47:0] value
   output logic [ffe_pkg::KIND_W-1:0]         rsp_tuser,   // [2:0] kind
   output logic                               rsp_tlast,   // frame_done
   input  logic                               csr_we,
   input  logic [ffe_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ffe_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   ffe_pkg::cmd_type    cmd;
   ffe_pkg::status_type status;

   ffe_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   ffe_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_sample (req_tdata),
      .req_last   (req_tlast),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_value  (rsp_tdata),
      .rsp_kind   (rsp_tuser),
      .rsp_done   (rsp_tlast)
   );

endmodule

### tb/sv/tb_frame_feature_extractor_core.sv
// self-checking testbench for the frame feature extractor core
module tb_frame_feature_extractor_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT   = 1_500_000;
   localparam int SETTLE_CYCLES = 80;
   localparam int IDLE_PCT      = 38;
   localparam int FRAME_CAP     = 65536;
   localparam int REPORT_MAX    = 10;

   localparam logic [ffe_pkg::SAMPLE_W-1:0] SAMPLE_MAX = 24'h7FFFFF;
   localparam logic [ffe_pkg::SAMPLE_W-1:0] SAMPLE_MIN = 24'h800000;

   typedef struct packed {
      logic [ffe_pkg::VALUE_W-1:0] value;
      logic [ffe_pkg::KIND_W-1:0]  kind;
      logic                        done;
   } feature_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [ffe_pkg::SAMPLE_W-1:0]     req_tdata = '0;
   logic                             req_tlast = 1'b0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [ffe_pkg::VALUE_W-1:0]      rsp_tdata;
   logic [ffe_pkg::KIND_W-1:0]       rsp_tuser;
   logic                             rsp_tlast;
   logic                             csr_we = 1'b0;
   logic [ffe_pkg::CSR_IDX_W-1:0]    csr_index = '0;
   logic [ffe_pkg::CSR_DATA_W-1:0]   csr_wdata = '0;

   // expected features, oldest first
   feature_type pending_features[$];
   int unsigned error_count = 0;
   int unsigned cycle_count = 0;
   bit          no_stall = 1'b0;
   feature_type got_feature, want_feature;

   // predictor copy of the registers and the frame state
   logic [ffe_pkg::MODE_W-1:0]          cur_mode = ffe_pkg::MODE_PASS;
   logic signed [ffe_pkg::THR_W-1:0]    cur_threshold = '0;
   logic [ffe_pkg::DIST_W-1:0]          cur_min_dist = '0;
   logic signed [ffe_pkg::SAMPLE_W-1:0] last_sample = '0;
   logic signed [ffe_pkg::SAMPLE_W-1:0] older_sample = '0;
   int unsigned                         frame_count = 0;
   logic [ffe_pkg::ACC_W-1:0]           frame_acc = '0;
   int unsigned                         peak_pos = 0;
   bit                                  have_peak = 1'b0;

   frame_feature_extractor_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_tready <= no_stall || ($urandom_range(0, 99) >= IDLE_PCT);
   end

   task automatic report_mismatch(string what, feature_type want, feature_type got);
      error_count++;
      if (error_count <= REPORT_MAX)
         $display("%s: expected value %h kind %0d done %0b, got value %h kind %0d done %0b",
                  what, want.value, want.kind, want.done, got.value, got.kind, got.done);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_feature = {rsp_tdata, rsp_tuser, rsp_tlast};
         if (pending_features.size() == 0) begin
            report_mismatch("unexpected result", '0, got_feature);
         end else begin
            want_feature = pending_features.pop_front();
            if (got_feature !== want_feature)
               report_mismatch("result mismatch", want_feature, got_feature);
         end
      end
   end

   task automatic push_feature(logic [63:0] v, logic [ffe_pkg::KIND_W-1:0] k, logic d);
      feature_type f;
      f.value = v[ffe_pkg::VALUE_W-1:0];
      f.kind  = k;
      f.done  = d;
      pending_features.insert(pending_features.size(), f);
   endtask

   task automatic predict_features(logic signed [ffe_pkg::SAMPLE_W-1:0] s, logic last);
      logic signed [63:0] sx;
      logic [63:0]        mag, quo, divisor;
      int unsigned        pos;
      sx = s;
      if (cur_mode == ffe_pkg::MODE_PASS)
         push_feature(sx, ffe_pkg::KIND_SAMPLE, last);
      // samples past the frame cap are not counted; passthrough still echoes them
      if (frame_count < FRAME_CAP) begin
         if (cur_mode == ffe_pkg::MODE_MEAN) begin
            frame_acc = frame_acc + sx;
         end else if (cur_mode == ffe_pkg::MODE_ENERGY) begin
            frame_acc = frame_acc + sx * sx;
         end else if (cur_mode == ffe_pkg::MODE_PEAK && frame_count >= 2) begin
            if (last_sample > older_sample && last_sample > s &&
                last_sample > cur_threshold) begin
               pos = frame_count - 1;
               if (!have_peak || (pos - peak_pos) >= cur_min_dist) begin
                  push_feature(64'(pos), ffe_pkg::KIND_PEAK, 1'b0);
                  peak_pos  = pos;
                  have_peak = 1'b1;
               end
            end
         end
         older_sample = last_sample;
         last_sample  = s;
         frame_count++;
      end
      if (last) begin
         divisor = (frame_count != 0) ? 64'(frame_count) : 64'd1;
         if (cur_mode == ffe_pkg::MODE_MEAN) begin
            mag = frame_acc[63] ? -frame_acc : frame_acc;
            quo = mag / divisor;
            push_feature(frame_acc[63] ? -quo : quo, ffe_pkg::KIND_MEAN, 1'b1);
         end else if (cur_mode == ffe_pkg::MODE_ENERGY) begin
            push_feature(frame_acc / divisor, ffe_pkg::KIND_ENERGY, 1'b1);
         end else if (cur_mode == ffe_pkg::MODE_PEAK) begin
            push_feature(64'd0, ffe_pkg::KIND_END, 1'b1);
         end
         last_sample  = '0;
         older_sample = '0;
         frame_count  = 0;
         frame_acc    = '0;
         peak_pos     = 0;
         have_peak    = 1'b0;
      end
   endtask

   // valid stays high after acceptance; an idle gap in the next call, a drain or a csr write takes it down
   task automatic send_sample(logic [ffe_pkg::SAMPLE_W-1:0] s, logic last);
      if (!no_stall) begin
         while ($urandom_range(0, 99) < IDLE_PCT) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= s;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_features(s, last);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_features.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [ffe_pkg::CSR_IDX_W-1:0] idx,
                            logic [ffe_pkg::CSR_DATA_W-1:0] data);
      req_tvalid <= 1'b0;
      csr_we     <= 1'b1;
      csr_index  <= idx;
      csr_wdata  <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         ffe_pkg::CSR_MODE:      cur_mode      = data[ffe_pkg::MODE_W-1:0];
         ffe_pkg::CSR_THRESHOLD: cur_threshold = data;
         ffe_pkg::CSR_MIN_DIST:  cur_min_dist  = data[ffe_pkg::DIST_W-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   function automatic logic [ffe_pkg::SAMPLE_W-1:0] pick_sample(int style);
      int v;
      case (style)
         0: return ffe_pkg::SAMPLE_W'($urandom);
         1: begin
            // small values so that peaks, plateaus and threshold edges show up
            v = int'($urandom_range(0, 16)) - 8;
            return v[ffe_pkg::SAMPLE_W-1:0];
         end
         default: begin
            case ($urandom_range(0, 3))
               0: return SAMPLE_MAX;
               1: return SAMPLE_MIN;
               2: return '0;
               default: return '1;
            endcase
         end
      endcase
   endfunction

   task automatic randomize_config();
      logic [ffe_pkg::CSR_DATA_W-1:0] word;
      word = ffe_pkg::CSR_DATA_W'($urandom);
      word[ffe_pkg::MODE_W-1:0] = ffe_pkg::MODE_W'($urandom_range(0, 3));
      csr_write(ffe_pkg::CSR_MODE, word);
      case ($urandom_range(0, 4))
         0: word = SAMPLE_MIN;
         1: word = SAMPLE_MAX;
         2: word = ffe_pkg::CSR_DATA_W'(int'($urandom_range(0, 8)) - 4);
         3: word = ffe_pkg::CSR_DATA_W'($urandom);
         default: word = '0;
      endcase
      csr_write(ffe_pkg::CSR_THRESHOLD, word);
      word = ffe_pkg::CSR_DATA_W'($urandom);
      case ($urandom_range(0, 5))
         0: word[ffe_pkg::DIST_W-1:0] = '1;
         1: word[ffe_pkg::DIST_W-1:0] = '0;
         2: ;
         default: word[ffe_pkg::DIST_W-1:0] = ffe_pkg::DIST_W'($urandom_range(0, 5));
      endcase
      csr_write(ffe_pkg::CSR_MIN_DIST, word);
   endtask

   // relies on the reset mode being passthrough
   task automatic test_passthrough_after_reset();
      send_sample(SAMPLE_MAX, 1'b0);
      send_sample(SAMPLE_MIN, 1'b0);
      send_sample('0, 1'b1);
      send_sample('1, 1'b1);
      drain_results();
   endtask

   task automatic test_mean_frames();
      csr_write(ffe_pkg::CSR_MODE, ffe_pkg::CSR_DATA_W'(ffe_pkg::MODE_MEAN));
      send_sample(SAMPLE_MAX, 1'b0);
      send_sample(SAMPLE_MAX, 1'b0);
      send_sample(SAMPLE_MAX, 1'b1);
      // negative sum truncates toward zero
      send_sample(-24'sd5, 1'b0);
      send_sample('0, 1'b0);
      send_sample('0, 1'b1);
      drain_results();
   endtask

   task automatic test_energy_frames();
      csr_write(ffe_pkg::CSR_MODE, ffe_pkg::CSR_DATA_W'(ffe_pkg::MODE_ENERGY));
      send_sample(SAMPLE_MIN, 1'b0);
      send_sample(SAMPLE_MAX, 1'b1);
      drain_results();
   endtask

   task automatic test_peak_frames();
      csr_write(ffe_pkg::CSR_MODE, ffe_pkg::CSR_DATA_W'(ffe_pkg::MODE_PEAK));
      csr_write(ffe_pkg::CSR_THRESHOLD, '0);
      csr_write(ffe_pkg::CSR_MIN_DIST, '0);
      send_sample(24'sd1, 1'b0);
      send_sample(24'sd5, 1'b0);
      send_sample(24'sd2, 1'b0);
      send_sample(24'sd7, 1'b0);
      send_sample(24'sd3, 1'b1);
      // two samples cannot hold a peak
      send_sample(24'sd1, 1'b0);
      send_sample(24'sd9, 1'b1);
      drain_results();
      csr_write(ffe_pkg::CSR_THRESHOLD, SAMPLE_MIN);
      csr_write(ffe_pkg::CSR_MIN_DIST, ffe_pkg::CSR_DATA_W'(3));
      for (int i = 0; i < 7; i++)
         send_sample((i % 2) ? 24'sd3 : 24'sd0, i == 6);
      drain_results();
   endtask

   task automatic test_random_frames(int unsigned item_goal, bit calm);
      int unsigned sent;
      int          len, style;
      sent = 0;
      no_stall <= calm;
      drain_results();
      randomize_config();
      while (sent < item_goal) begin
         if ($urandom_range(0, 3) == 0) begin
            drain_results();
            randomize_config();
         end
         len   = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
         style = $urandom_range(0, 2);
         for (int i = 0; i < len; i++) begin
            if (i > 0 && $urandom_range(0, 60) == 0) begin
               drain_results();
               csr_write(ffe_pkg::CSR_MODE, ffe_pkg::CSR_DATA_W'($urandom_range(0, 3)));
            end
            send_sample(pick_sample(style), i == len - 1);
         end
         sent += len;
      end
      drain_results();
      no_stall <= 1'b0;
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_passthrough_after_reset();
      test_mean_frames();
      test_energy_frames();
      test_peak_frames();
      test_random_frames(280, 1'b0);
      test_random_frames(140, 1'b1);
      test_random_frames(200, 1'b0);
      drain_results();
      if (error_count == 0 && pending_features.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

### filelist.f
rtl/core/ffe_pkg.sv
rtl/core/ffe_ctrl.sv
rtl/core/ffe_dp.sv
rtl/core/frame_feature_extractor_core.sv
tb/sv/tb_frame_feature_extractor_core.sv
